@@ hw/rtl/rvc_pkg.sv @@
// rvc_pkg: shared constants and types for the frame parser.
// Used by rvc_front, rvc_queue, rvc_back and rvc_frame_parser; no dependencies.
`default_nettype none

package rvc_pkg;

    // Frame layout
    localparam logic [7:0] HDR_BYTE    = 8'hAA;
    localparam int         CNT_W       = 5;
    localparam int         IDX_W       = 4;
    localparam logic [CNT_W-1:0] CHECK_POS = 5'd16;  // position of the checksum byte
    localparam int         STORE_DEPTH = 13;
    localparam logic [IDX_W-1:0] STORE_LEN = 4'd13;  // payload bytes kept for output
    localparam logic [IDX_W-1:0] FIRST_POS = 4'd0;

    // Front-to-back queue
    localparam int         QUEUE_DEPTH = 2;

    // Kind of a classified payload item
    typedef enum logic {
        K_DATA  = 1'b0,
        K_CHECK = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } t_entry;

endpackage

`default_nettype wire

@@ hw/rtl/rvc_front.sv @@
// rvc_front: header hunt and payload classification.
// Depends on rvc_pkg; pushes classified payload items into rvc_queue.
`default_nettype none

module rvc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_full,
    output logic               o_stall,
    output logic               o_push,
    output rvc_pkg::t_entry    o_entry
);

    typedef enum logic [2:0] {
        S_HUNT = 3'b001,
        S_HDR1 = 3'b010,
        S_DATA = 3'b100
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [rvc_pkg::CNT_W-1:0]   r_count, n_count;
    logic                        accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    // Payload bytes go to the back end tagged with their position
    assign o_push        = accept && (r_phase == S_DATA);
    assign o_entry.kind  = (r_count == rvc_pkg::CHECK_POS) ? rvc_pkg::K_CHECK
                                                           : rvc_pkg::K_DATA;
    assign o_entry.idx   = r_count[rvc_pkg::IDX_W-1:0];
    assign o_entry.data  = i_rx_byte;

    // Phase and payload position
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (accept) begin
            unique case (r_phase)
                S_HUNT: begin
                    n_phase = (i_rx_byte == rvc_pkg::HDR_BYTE) ? S_HDR1 : S_HUNT;
                end
                S_HDR1: begin
                    n_phase = (i_rx_byte == rvc_pkg::HDR_BYTE) ? S_DATA : S_HUNT;
                    n_count = '0;
                end
                S_DATA: begin
                    if (r_count == rvc_pkg::CHECK_POS) begin
                        n_phase = S_HUNT;
                        n_count = '0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                default: begin
                    n_phase = S_HUNT;
                    n_count = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_HUNT;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rvc_queue.sv @@
// rvc_queue: small register FIFO between front and back ends.
// Depends on rvc_pkg for the item type.
`default_nettype none

module rvc_queue #(
    parameter int DEPTH = rvc_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rvc_pkg::t_entry i_entry,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire logic            i_pop,
    output rvc_pkg::t_entry      o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    rvc_pkg::t_entry   r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rvc_back.sv @@
// rvc_back: payload store, running checksum and result register.
// Depends on rvc_pkg; drains items from rvc_queue.
`default_nettype none

module rvc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire rvc_pkg::t_entry i_q_entry,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [7:0]           o_frame_index,
    output logic signed [15:0]   o_yaw_centideg,
    output logic signed [15:0]   o_pitch_centideg,
    output logic signed [15:0]   o_roll_centideg,
    output logic signed [15:0]   o_accel_x_milli,
    output logic signed [15:0]   o_accel_y_milli,
    output logic signed [15:0]   o_accel_z_milli,
    output logic                 o_checksum_ok,
    output logic [7:0]           o_received_checksum,
    output logic [7:0]           o_computed_checksum
);

    logic [7:0]   r_store [rvc_pkg::STORE_DEPTH];
    logic [7:0]   r_sum, n_sum;
    logic         r_valid;
    logic         out_free, is_check, pop_data, pop_check;

    // Data items never wait; the checksum item waits for a free result slot
    assign out_free  = !r_valid || !i_stall;
    assign is_check  = (i_q_entry.kind == rvc_pkg::K_CHECK);
    assign o_pop     = i_q_valid && (!is_check || out_free);
    assign pop_data  = o_pop && !is_check;
    assign pop_check = o_pop && is_check;
    assign o_valid   = r_valid;

    // Running sum restarts at the first payload byte
    assign n_sum = (i_q_entry.idx == rvc_pkg::FIRST_POS) ? i_q_entry.data
                                                          : r_sum + i_q_entry.data;

    always_ff @(posedge i_clk) begin
        if (pop_data) begin
            r_sum <= n_sum;
            if (i_q_entry.idx < rvc_pkg::STORE_LEN) begin
                r_store[i_q_entry.idx] <= i_q_entry.data;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (pop_check) begin
            o_frame_index       <= r_store[0];
            o_yaw_centideg      <= {r_store[2],  r_store[1]};
            o_pitch_centideg    <= {r_store[4],  r_store[3]};
            o_roll_centideg     <= {r_store[6],  r_store[5]};
            o_accel_x_milli     <= {r_store[8],  r_store[7]};
            o_accel_y_milli     <= {r_store[10], r_store[9]};
            o_accel_z_milli     <= {r_store[12], r_store[11]};
            o_checksum_ok       <= (r_sum == i_q_entry.data);
            o_received_checksum <= i_q_entry.data;
            o_computed_checksum <= r_sum;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (pop_check) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rvc_frame_parser.sv @@
// rvc_frame_parser: top level of the byte-serial IMU frame parser.
// Depends on rvc_pkg, rvc_front, rvc_queue and rvc_back.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------
//   in      | i_in_valid / o_in_stall | i_rx_byte
//   out     | o_out_valid / i_out_stall | frame_index, six angles/accels,
//           |                         | checksum_ok, received/computed sum
//
// One byte is taken per cycle unless the input is stalled. A result is shown
// from the back end's result register after its checksum leaves the queue.
// Reset is synchronous, active low; it clears phase, queue and result valid.
// The input stalls only when the queue is full, which happens only while a
// finished result is held by a stalled output.
`default_nettype none

module rvc_frame_parser #(
    parameter int QUEUE_DEPTH = rvc_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [7:0]         o_frame_index,
    output logic signed [15:0] o_yaw_centideg,
    output logic signed [15:0] o_pitch_centideg,
    output logic signed [15:0] o_roll_centideg,
    output logic signed [15:0] o_accel_x_milli,
    output logic signed [15:0] o_accel_y_milli,
    output logic signed [15:0] o_accel_z_milli,
    output logic               o_checksum_ok,
    output logic [7:0]         o_received_checksum,
    output logic [7:0]         o_computed_checksum
);

    logic             q_full, q_push, q_valid, q_pop;
    rvc_pkg::t_entry  q_wr_entry, q_rd_entry;

    rvc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_rx_byte (i_rx_byte),
        .i_full    (q_full),
        .o_stall   (o_in_stall),
        .o_push    (q_push),
        .o_entry   (q_wr_entry)
    );

    rvc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_entry (q_rd_entry)
    );

    rvc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_entry           (q_rd_entry),
        .o_pop               (q_pop),
        .o_valid             (o_out_valid),
        .i_stall             (i_out_stall),
        .o_frame_index       (o_frame_index),
        .o_yaw_centideg      (o_yaw_centideg),
        .o_pitch_centideg    (o_pitch_centideg),
        .o_roll_centideg     (o_roll_centideg),
        .o_accel_x_milli     (o_accel_x_milli),
        .o_accel_y_milli     (o_accel_y_milli),
        .o_accel_z_milli     (o_accel_z_milli),
        .o_checksum_ok       (o_checksum_ok),
        .o_received_checksum (o_received_checksum),
        .o_computed_checksum (o_computed_checksum)
    );

    // No result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Match flag agrees with the two sums it reports
    a_sum_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_checksum_ok == (o_received_checksum == o_computed_checksum)))
        else $error("checksum flag inconsistent");

    // Input back-pressure only comes from a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // A popped checksum item always produces a result next cycle
    a_check_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q_rd_entry.kind == rvc_pkg::K_CHECK) |=> o_out_valid)
        else $error("checksum item lost");

endmodule

`default_nettype wire
